/* design/wsd_pkg.sv */
// Package for the WebSocket frame deframer: item types, result kinds, queue sizing.
// Used by every module of the design folder; depends on nothing.
package wsd_pkg;

	localparam int LEN_W = 63;
	localparam int QUEUE_DEPTH_DEF = 4;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_TRUNC   = 2'd2;

	// second header byte length codes
	localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
	localparam logic [6:0] LEN7_EXT16     = 7'd126;

	// header bytes that follow the second byte
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             fin;
		logic [3:0]       opcode;
		logic             masked;
		logic [LEN_W-1:0] frame_len;
		logic [7:0]       payload_byte;
		logic             last_of_frame;
	} out_item_t;

	// classified item passed from the parser to the output stage
	typedef struct packed {
		logic [1:0]       kind;
		logic             fin;
		logic [3:0]       opcode;
		logic             masked;
		logic [LEN_W-1:0] frame_len;
		logic [7:0]       data;
		logic [7:0]       key;
		logic             last;
	} q_entry_t;

endpackage

/* design/wsd_parser.sv */
// Front end of the deframer: header parser that classifies each received byte.
// Depends on wsd_pkg; pushes classified items into wsd_queue.
module wsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  wsd_pkg::in_item_t item,
	output logic              push,
	output wsd_pkg::q_entry_t entry
);
	import wsd_pkg::*;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_SECOND  = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	logic [2:0]       phase_q;
	logic             fin_q;
	logic [3:0]       opcode_q;
	logic             mask_q;
	logic [LEN_W-1:0] len_q;
	logic [3:0]       cnt_q;
	logic [31:0]      key_q;
	logic [LEN_W-1:0] rem_q;
	logic [1:0]       kidx_q;

	logic             hdr_done;
	logic             hdr_mask;
	logic [LEN_W-1:0] hdr_len;
	logic [LEN_W-1:0] len_shift;
	logic [6:0]       len7;
	logic             last_byte;
	logic [7:0]       key_byte;

	assign len7      = item.rx_byte[6:0];
	assign len_shift = {len_q[LEN_W-9:0], item.rx_byte};
	assign last_byte = (rem_q == {{(LEN_W-1){1'b0}}, 1'b1});

	// pick the key byte for this payload position, first key byte on top
	always_comb begin
		case (kidx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
			default: key_byte = key_q[31:24];
		endcase
	end

	// detect header completion on this byte
	always_comb begin
		hdr_done = 1'b0;
		hdr_mask = mask_q;
		hdr_len  = len_q;
		case (phase_q)
			PH_SECOND: begin
				hdr_mask = item.rx_byte[7];
				hdr_len  = {{(LEN_W-7){1'b0}}, len7};
				hdr_done = (len7 <= LEN7_MAX_SHORT) && !item.rx_byte[7];
			end
			PH_EXTLEN: begin
				hdr_len  = len_shift;
				hdr_done = (cnt_q == 4'd1) && !mask_q;
			end
			PH_KEY: begin
				hdr_done = (cnt_q == 4'd1);
			end
			default: begin
				hdr_done = 1'b0;
			end
		endcase
	end

	// classify the byte into a queue item
	always_comb begin
		push                 = 1'b0;
		entry                = '0;
		entry.fin            = fin_q;
		entry.opcode         = opcode_q;
		entry.masked         = mask_q;
		if (item.stream_end) begin
			entry.kind = KIND_TRUNC;
			entry.last = 1'b1;
			push       = accept && (phase_q >= PH_SECOND) && (phase_q <= PH_PAYLOAD);
		end else if (hdr_done) begin
			entry.kind           = KIND_HEADER;
			entry.masked         = hdr_mask;
			entry.frame_len      = hdr_len;
			entry.last           = (hdr_len == '0);
			push                 = accept;
		end else if (phase_q == PH_PAYLOAD) begin
			entry.kind           = KIND_PAYLOAD;
			entry.frame_len      = len_q;
			entry.data           = item.rx_byte;
			entry.key            = mask_q ? key_byte : 8'd0;
			entry.last           = last_byte;
			push                 = accept;
		end
	end

	// advance the header state on every accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			fin_q    <= 1'b0;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			cnt_q    <= 4'd0;
			key_q    <= 32'd0;
			rem_q    <= '0;
			kidx_q   <= 2'd0;
		end else if (accept) begin
			if (item.stream_end || (hdr_done && hdr_len == '0) ||
				(!hdr_done && phase_q == PH_PAYLOAD && last_byte)) begin
				// frame over: back to idle
				phase_q  <= PH_IDLE;
				fin_q    <= 1'b0;
				opcode_q <= 4'd0;
				mask_q   <= 1'b0;
				len_q    <= '0;
				cnt_q    <= 4'd0;
				key_q    <= 32'd0;
				rem_q    <= '0;
				kidx_q   <= 2'd0;
			end else if (hdr_done) begin
				mask_q  <= hdr_mask;
				len_q   <= hdr_len;
				cnt_q   <= 4'd0;
				rem_q   <= hdr_len;
				kidx_q  <= 2'd0;
				phase_q <= PH_PAYLOAD;
				if (phase_q == PH_KEY) begin
					key_q <= {key_q[23:0], item.rx_byte};
				end
			end else begin
				case (phase_q)
					PH_SECOND: begin
						mask_q <= item.rx_byte[7];
						if (len7 <= LEN7_MAX_SHORT) begin
							// short length with key to follow
							len_q   <= {{(LEN_W-7){1'b0}}, len7};
							cnt_q   <= KEY_BYTES;
							key_q   <= 32'd0;
							phase_q <= PH_KEY;
						end else begin
							len_q   <= '0;
							cnt_q   <= (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
							phase_q <= PH_EXTLEN;
						end
					end
					PH_EXTLEN: begin
						len_q <= len_shift;
						if (cnt_q == 4'd1) begin
							cnt_q   <= KEY_BYTES;
							key_q   <= 32'd0;
							phase_q <= PH_KEY;
						end else begin
							cnt_q <= cnt_q - 4'd1;
						end
					end
					PH_KEY: begin
						key_q <= {key_q[23:0], item.rx_byte};
						cnt_q <= cnt_q - 4'd1;
					end
					PH_PAYLOAD: begin
						kidx_q <= kidx_q + 2'd1;
						rem_q  <= rem_q - {{(LEN_W-1){1'b0}}, 1'b1};
					end
					default: begin
						// idle and unused codes: take the first header byte
						fin_q    <= item.rx_byte[7];
						opcode_q <= item.rx_byte[3:0];
						mask_q   <= 1'b0;
						len_q    <= '0;
						phase_q  <= PH_SECOND;
					end
				endcase
			end
		end
	end

	a_payload_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (rem_q != '0))
		else $error("payload phase with no bytes remaining");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && entry.last) |=> (phase_q == PH_IDLE))
		else $error("frame ended but parser not idle");

endmodule

/* design/wsd_queue.sv */
// Short queue of classified items between the parser and the output stage.
// Depends on wsd_pkg for the entry type.
module wsd_queue #(
	parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsd_pkg::q_entry_t wr_entry,
	input  logic              pop,
	output wsd_pkg::q_entry_t rd_entry,
	output logic              full,
	output logic              empty
);
	import wsd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	q_entry_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == DEPTH_CNT);
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

/* design/wsd_unmask.sv */
// Back end of the deframer: unmasks payload bytes and holds the result register.
// Depends on wsd_pkg; drains wsd_queue.
module wsd_unmask (
	input  logic               clk,
	input  logic               arst_n,
	input  wsd_pkg::q_entry_t  entry,
	input  logic               empty,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output wsd_pkg::out_item_t result
);
	import wsd_pkg::*;

	logic      valid_q;
	out_item_t out_q;

	assign pop          = !empty && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result       = out_q;

	// load the result register when it is free or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !result_stall) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.kind           <= entry.kind;
			out_q.fin            <= entry.fin;
			out_q.opcode         <= entry.opcode;
			out_q.masked         <= entry.masked;
			out_q.frame_len      <= entry.frame_len;
			out_q.payload_byte   <= entry.data ^ entry.key;
			out_q.last_of_frame  <= entry.last;
		end
	end

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (out_q.kind == KIND_HEADER || out_q.kind == KIND_PAYLOAD ||
			out_q.kind == KIND_TRUNC))
		else $error("result carries an undefined kind");

endmodule

/* design/websocket_frame_deframer.sv */
// WebSocket frame deframer (receive side): header parse, payload unmask.
// Instantiates wsd_parser, wsd_queue and wsd_unmask; depends on wsd_pkg.
//
// Usage:
//   Input channel byte_item/byte_valid/byte_stall carries one stream byte per
//   item, or a stream end marker. Output channel result/result_valid/
//   result_stall carries one result per header, payload byte or truncation.
//   Header bytes before the last one produce no result.
// Path: an accepted byte's item is written into the queue at the accepting edge,
//   and the output register loads it from the queue when that register is free
//   or being taken.
// Throughput: one byte per cycle while byte_stall is low. The parser updates
//   its header state on each accepted byte, and the queue plus output register
//   let the next byte enter while a result is still waiting.
// Stall: when the receiver stalls, the output register holds its item and
//   the queue fills; byte_stall rises once the queue is full.
// Reset: arst_n clears the parser to idle and empties the queue and the
//   output register. No clearing pass is needed.
module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wsd_pkg::in_item_t  byte_item,
	input  logic               byte_valid,
	output logic               byte_stall,
	output wsd_pkg::out_item_t result,
	output logic               result_valid,
	input  logic               result_stall
);
	import wsd_pkg::*;

	logic     accept;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;
	q_entry_t wr_entry;
	q_entry_t rd_entry;

	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	wsd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_item),
		.push   (push),
		.entry  (wr_entry)
	);

	wsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (full),
		.empty    (empty)
	);

	wsd_unmask u_unmask (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry        (rd_entry),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
